FILE: sv/assert_macros.svh
// Assertion macros used by the top-level RTL file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`define CHK_IMPL(lbl, clk, rst_n, a, c) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (c)) else $error("%m failed");
`define CHK_NEXT(lbl, clk, rst_n, a, c) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (c)) else $error("%m failed");
`endif

FILE: sv/qmo_pkg.sv
// Package: types and constants for quad mesh orientation propagation
`default_nettype none
package qmo_pkg;
    localparam int MaxElems = 64;
    localparam int VertexIdBits = 12;
    localparam int CountBits = 7;
    localparam logic FuncLoad = 1'b0;
    localparam logic FuncRun = 1'b1;
    typedef enum logic [3:0] {
        S_IDLE, S_CLEAR, S_RD_QUAD, S_WAIT_QUAD, S_RD_NBR, S_WAIT_NBR, S_DECIDE,
        S_SCAN, S_EMIT_RD, S_EMIT_WAIT, S_EMIT
    } t_state;
endpackage
`default_nettype wire

FILE: sv/qmo_ram.sv
// Generic single-port-write, one-read RAM with registered read
`default_nettype none
module qmo_ram #(
    parameter int Width = 8,
    parameter int Depth = 64
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(Depth)-1:0] i_waddr,
    input  wire logic [Width-1:0]         i_wdata,
    input  wire logic [$clog2(Depth)-1:0] i_raddr,
    output logic      [Width-1:0]         o_rdata
);
    logic [Width-1:0] r_mem [Depth];
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end
endmodule
`default_nettype wire

FILE: sv/quad_mesh_orientation_propagate.sv
// Top level: quad mesh orientation propagation
// A load (func 0) writes one quad entry. A run (func 1) clears the visited and flip
// marks (quad 0 is then marked visited), then makes passes over the quads through the
// single read port of the vertex memory: a visited quad is skipped, and an unvisited
// quad reads its entry and neighbors, then uses its first visited neighbor, if any.
// Passes repeat until one marks nothing; then each result is read and emitted in turn,
// subject to output stalls.
// Marks live in flip-flops.
`default_nettype none
module quad_mesh_orientation_propagate #(
    parameter int MaxElems = qmo_pkg::MaxElems,
    parameter int VertexIdBits = qmo_pkg::VertexIdBits
) (
    input  wire logic                         i_clk,
    input  wire logic                         i_rst_n,
    input  wire logic                         i_cfg_we,
    input  wire logic [qmo_pkg::CountBits-1:0] i_cfg_wdata,
    input  wire logic                         i_valid,
    output logic                              o_ready,
    input  wire logic                         i_func,
    input  wire logic [5:0]                   i_elem_index,
    input  wire logic [VertexIdBits-1:0]      i_vert0,
    input  wire logic [VertexIdBits-1:0]      i_vert1,
    input  wire logic [VertexIdBits-1:0]      i_vert2,
    input  wire logic [VertexIdBits-1:0]      i_vert3,
    input  wire logic [5:0]                   i_nbr0,
    input  wire logic [5:0]                   i_nbr1,
    input  wire logic [5:0]                   i_nbr2,
    input  wire logic [5:0]                   i_nbr3,
    output logic                              o_valid,
    input  wire logic                         i_ready,
    output logic [5:0]                        o_out_index,
    output logic [VertexIdBits-1:0]           o_out_vert0,
    output logic [VertexIdBits-1:0]           o_out_vert1,
    output logic [VertexIdBits-1:0]           o_out_vert2,
    output logic [VertexIdBits-1:0]           o_out_vert3,
    output logic                              o_was_flipped,
    output logic                              o_incomplete,
    output logic                              o_last_result
);
    `include "assert_macros.svh"
    localparam int Ab = $clog2(MaxElems);
    localparam int Vw = 4 * VertexIdBits;
    localparam int Cb = qmo_pkg::CountBits;

    qmo_pkg::t_state r_state, n_state;
    logic [Cb-1:0] r_cfg;
    logic [Cb-1:0] r_n, n_n;
    logic [Ab-1:0] r_el, n_el;
    logic [2:0]    r_k, n_k;
    logic [MaxElems-1:0] r_vis, n_vis, r_flp, n_flp;
    logic r_marked, n_marked;
    logic [Vw-1:0] r_quad, n_quad;
    logic [23:0]   r_nbrs, n_nbrs;

    logic          v_we;
    logic [Ab-1:0] v_waddr, v_raddr;
    logic [Vw-1:0] v_wdata, v_rdata;
    logic [23:0]   nb_rdata;
    logic          nb_we;

    logic [Cb-1:0] cnt_eff;
    always_comb begin
        cnt_eff = r_cfg;
        if (r_cfg == '0) cnt_eff = Cb'(1);
        if (r_cfg > Cb'(MaxElems)) cnt_eff = Cb'(MaxElems);
    end

    qmo_ram #(.Width(Vw), .Depth(MaxElems)) u_vert (
        .i_clk(i_clk), .i_we(v_we), .i_waddr(v_waddr), .i_wdata(v_wdata),
        .i_raddr(v_raddr), .o_rdata(v_rdata));
    qmo_ram #(.Width(24), .Depth(MaxElems)) u_nbr (
        .i_clk(i_clk), .i_we(nb_we), .i_waddr(i_elem_index[Ab-1:0]),
        .i_wdata({i_nbr3, i_nbr2, i_nbr1, i_nbr0}), .i_raddr(r_el), .o_rdata(nb_rdata));

    // candidate neighbor of the current quad
    logic [5:0] cand;
    logic       cand_ok;
    logic       load_ok;
    always_comb begin
        cand = r_nbrs[6*r_k[1:0] +: 6];
        cand_ok = ({1'b0, cand} < r_n) && r_vis[cand[Ab-1:0]];
        load_ok = ({1'b0, i_elem_index} < Cb'(MaxElems));
    end

    // flip decision between r_quad (own) and v_rdata (neighbor)
    logic [VertexIdBits-1:0] a [4];
    logic [VertexIdBits-1:0] b [4];
    logic flip_need, found_e;
    logic [VertexIdBits-1:0] f1, s1, succ;
    logic h1, h2;
    always_comb begin
        for (int j = 0; j < 4; j++) begin
            a[j] = r_quad[j*VertexIdBits +: VertexIdBits];
            b[j] = v_rdata[j*VertexIdBits +: VertexIdBits];
        end
        flip_need = 1'b0;
        found_e = 1'b0;
        succ = '0;
        for (int i = 0; i < 4; i++) begin
            f1 = a[i];
            s1 = a[(i+1)%4];
            h1 = (b[0] == f1) || (b[1] == f1) || (b[2] == f1) || (b[3] == f1);
            h2 = (b[0] == s1) || (b[1] == s1) || (b[2] == s1) || (b[3] == s1);
            if (!found_e && h1 && h2) begin
                found_e = 1'b1;
                succ = '0;
                for (int j = 0; j < 4; j++) if (b[j] == f1) succ = b[(j+1)%4];
                flip_need = (succ == s1);
            end
        end
    end

    always_comb begin
        n_state = r_state; n_n = r_n; n_el = r_el; n_k = r_k; n_vis = r_vis;
        n_flp = r_flp; n_marked = r_marked; n_quad = r_quad; n_nbrs = r_nbrs;
        o_ready = 1'b0; o_valid = 1'b0;
        v_we = 1'b0; v_waddr = i_elem_index[Ab-1:0];
        v_wdata = {i_vert3, i_vert2, i_vert1, i_vert0};
        v_raddr = r_el; nb_we = 1'b0;
        case (r_state)
            qmo_pkg::S_IDLE: begin
                o_ready = 1'b1;
                if (i_valid) begin
                    if (i_func == qmo_pkg::FuncLoad) begin
                        v_we = load_ok; nb_we = load_ok;
                    end else begin
                        n_n = cnt_eff; n_el = '0; n_state = qmo_pkg::S_CLEAR;
                    end
                end
            end
            qmo_pkg::S_CLEAR: begin
                n_vis = '0; n_vis[0] = 1'b1; n_flp = '0; n_marked = 1'b0;
                n_el = '0; n_state = qmo_pkg::S_RD_QUAD;
            end
            qmo_pkg::S_RD_QUAD: begin
                if (r_vis[r_el]) begin
                    n_state = qmo_pkg::S_SCAN;
                end else begin
                    n_state = qmo_pkg::S_WAIT_QUAD;
                end
            end
            qmo_pkg::S_WAIT_QUAD: begin
                n_quad = v_rdata; n_nbrs = nb_rdata; n_k = '0;
                n_state = qmo_pkg::S_RD_NBR;
            end
            qmo_pkg::S_RD_NBR: begin
                if (r_k == 3'd4) begin
                    n_state = qmo_pkg::S_SCAN;
                end else if (cand_ok) begin
                    v_raddr = cand[Ab-1:0];
                    n_state = qmo_pkg::S_WAIT_NBR;
                end else begin
                    n_k = r_k + 3'd1;
                end
            end
            qmo_pkg::S_WAIT_NBR: begin
                v_raddr = cand[Ab-1:0];
                n_state = qmo_pkg::S_DECIDE;
            end
            qmo_pkg::S_DECIDE: begin
                v_waddr = r_el;
                v_wdata = {a[0], a[1], a[2], a[3]};
                v_we = flip_need;
                n_flp[r_el] = flip_need;
                n_vis[r_el] = 1'b1;
                n_marked = 1'b1;
                n_state = qmo_pkg::S_SCAN;
            end
            qmo_pkg::S_SCAN: begin
                if ({1'b0, r_el} + Cb'(1) >= r_n) begin
                    n_el = '0;
                    if (r_marked) begin
                        n_marked = 1'b0; n_state = qmo_pkg::S_RD_QUAD;
                    end else begin
                        n_state = qmo_pkg::S_EMIT_RD;
                    end
                end else begin
                    n_el = r_el + Ab'(1); n_state = qmo_pkg::S_RD_QUAD;
                end
            end
            qmo_pkg::S_EMIT_RD: n_state = qmo_pkg::S_EMIT_WAIT;
            qmo_pkg::S_EMIT_WAIT: begin
                n_quad = v_rdata; n_state = qmo_pkg::S_EMIT;
            end
            qmo_pkg::S_EMIT: begin
                o_valid = 1'b1;
                if (i_ready) begin
                    if (o_last_result) begin
                        n_state = qmo_pkg::S_IDLE;
                    end else begin
                        n_el = r_el + Ab'(1); n_state = qmo_pkg::S_EMIT_RD;
                    end
                end
            end
            default: n_state = qmo_pkg::S_IDLE;
        endcase
    end

    logic [MaxElems-1:0] in_range;
    always_comb begin
        for (int j = 0; j < MaxElems; j++) in_range[j] = (Cb'(j) < r_n);
    end

    assign o_out_index   = 6'(r_el);
    assign o_out_vert0   = r_quad[0*VertexIdBits +: VertexIdBits];
    assign o_out_vert1   = r_quad[1*VertexIdBits +: VertexIdBits];
    assign o_out_vert2   = r_quad[2*VertexIdBits +: VertexIdBits];
    assign o_out_vert3   = r_quad[3*VertexIdBits +: VertexIdBits];
    assign o_was_flipped = r_flp[r_el];
    assign o_incomplete  = |(in_range & ~r_vis);
    assign o_last_result = ({1'b0, r_el} + Cb'(1) == r_n);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= qmo_pkg::S_IDLE;
            r_cfg <= Cb'(1);
            r_vis <= '0;
            r_flp <= '0;
            r_marked <= 1'b0;
            r_n <= Cb'(1);
            r_el <= '0;
            r_k <= '0;
        end else begin
            r_state <= n_state;
            if (i_cfg_we) r_cfg <= i_cfg_wdata;
            r_vis <= n_vis;
            r_flp <= n_flp;
            r_marked <= n_marked;
            r_n <= n_n;
            r_el <= n_el;
            r_k <= n_k;
        end
    end
    always_ff @(posedge i_clk) begin
        r_quad <= n_quad;
        r_nbrs <= n_nbrs;
    end

    `CHK_IMPL(a_out_idle_excl, i_clk, i_rst_n, o_valid, !o_ready)
    `CHK_IMPL(a_quad0_visited, i_clk, i_rst_n, o_valid, r_vis[0])
    `CHK_IMPL(a_flip_implies_vis, i_clk, i_rst_n, o_valid && o_was_flipped, r_vis[r_el])
    `CHK_NEXT(a_last_to_idle, i_clk, i_rst_n, o_valid && i_ready && o_last_result, o_ready)
endmodule
`default_nettype wire
